// File: hdl/bdq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, codes and controller/datapath handshake types for the
// bounded deque.
// ---------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam int EXT_W   = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

	localparam int OP_W     = 3;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int ECOUNT_W = 5;

	typedef logic [OP_W-1:0]       op_t;
	typedef logic [WORD_W-1:0]     word_t;
	typedef logic [STATUS_W-1:0]   status_t;
	typedef logic [ECOUNT_W-1:0]   ecount_t;
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [COUNT_W-1:0]    count_t;

	localparam op_t OP_PUSH_FRONT = 3'd0;
	localparam op_t OP_PUSH_BACK  = 3'd1;
	localparam op_t OP_POP_FRONT  = 3'd2;
	localparam op_t OP_POP_BACK   = 3'd3;
	localparam op_t OP_REVERSE    = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef struct packed {
		logic latch;
		logic exec;
		logic load_rd;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pop_hit;
	} dp_sts_t;

	function automatic data_t word_to_data(input word_t w);
		logic [EXT_W-1:0] e;
		e = EXT_W'(w);
		return e[DATA_WIDTH-1:0];
	endfunction

	function automatic word_t data_to_word(input data_t d);
		logic [EXT_W-1:0] e;
		e = EXT_W'(d);
		return e[WORD_W-1:0];
	endfunction

	function automatic addr_t ring_next(input addr_t i);
		return (i == addr_t'(DEPTH - 1)) ? '0 : addr_t'(i + 1'b1);
	endfunction

	function automatic addr_t ring_prev(input addr_t i);
		return (i == '0) ? addr_t'(DEPTH - 1) : addr_t'(i - 1'b1);
	endfunction

	function automatic addr_t ring_add(input addr_t i, input addr_t k);
		logic [ADDR_W:0] s;
		s = {1'b0, i} + {1'b0, k};
		if (s >= (ADDR_W + 1)'(DEPTH)) begin
			s = s - (ADDR_W + 1)'(DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

endpackage

// File: hdl/bdq_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdq_in_if
// Operation channel: one word carries an op code and a data value.
// ---------------------------------------------------------------------------
interface bdq_in_if import bdq_pkg::*; ();
	logic  valid;
	logic  ready;
	op_t   op;
	word_t value_in;

	modport source(output valid, output op, output value_in, input ready);
	modport sink(input valid, input op, input value_in, output ready);
endinterface

// File: hdl/bdq_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdq_out_if
// Result channel: popped value, status, count and empty flag.
// ---------------------------------------------------------------------------
interface bdq_out_if import bdq_pkg::*; ();
	logic    valid;
	logic    ready;
	word_t   value_out;
	status_t status;
	ecount_t entry_count;
	logic    is_empty;

	modport source(output valid, output value_out, output status,
		output entry_count, output is_empty, input ready);
	modport sink(input valid, input value_out, input status,
		input entry_count, input is_empty, output ready);
endinterface

// File: hdl/bounded_deque_with_reverse.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_deque_with_reverse
// Bounded double-ended queue on a ring of slots with one-step reversal.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one word per operation: op (push front/back, pop front/back,
//   reverse) and value_in. rsp returns exactly one word per operation:
//   value_out (popped word, else zero), status (ok, empty, full),
//   entry_count and is_empty after the operation.
//   One operation is in flight at a time. Pushes, reverse, unused op codes
//   and rejected operations pass through an execute state and then present
//   the result on rsp; a successful pop adds a read state between the two,
//   for the registered read of the slot RAM. req.ready rises again the cycle
//   after the result word is taken.
//   If the receiver holds rsp.ready low, the result word stays on rsp and
//   req.ready stays low until it is taken.
//   Reset empties the queue and restores normal order; slot contents are
//   not cleared, and no slot is read before it is written.
// ---------------------------------------------------------------------------
module bounded_deque_with_reverse import bdq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bdq_in_if.sink    req,
	bdq_out_if.source rsp
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.op         (req.op),
		.value_in   (req.value_in),
		.sts        (sts),
		.value_out  (rsp.value_out),
		.status     (rsp.status),
		.entry_count(rsp.entry_count),
		.is_empty   (rsp.is_empty)
	);

endmodule

// File: hdl/bdq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/bdq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept, execute, optional slot read, present result.
// ---------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.pop_hit ? S_READ : S_OUT;
			end
			S_READ: begin
				cmd.load_rd = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/bdq_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdq_dp
// Datapath: ring pointers, direction flag, slot RAM and result registers.
// ---------------------------------------------------------------------------
module bdq_dp import bdq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	input  op_t       op,
	input  word_t     value_in,
	output dp_sts_t   sts,
	output word_t     value_out,
	output status_t   status,
	output ecount_t   entry_count,
	output logic      is_empty
);

	op_t     op_q;
	data_t   data_q;
	addr_t   front_q;
	count_t  count_q;
	logic    rev_q;
	word_t   value_out_q;
	status_t status_q;
	count_t  res_count_q;

	logic    is_push;
	logic    is_pop;
	logic    full;
	logic    empty;
	logic    low_end;
	logic    push_ok;
	addr_t   high_addr;
	addr_t   wr_addr;
	addr_t   rd_addr;
	addr_t   front_d;
	count_t  count_d;
	status_t status_d;
	data_t   rd_data;

	always_comb begin
		is_push   = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
		is_pop    = (op_q == OP_POP_FRONT) || (op_q == OP_POP_BACK);
		full      = (count_q == count_t'(DEPTH));
		empty     = (count_q == '0);
		low_end   = is_push ? ((op_q == OP_PUSH_FRONT) ^ rev_q)
		                    : ((op_q == OP_POP_FRONT) ^ rev_q);
		push_ok   = is_push && !full;
		sts.pop_hit = is_pop && !empty;
		// push at high end writes at front+count, pop reads front+count-1
		high_addr = ring_add(front_q,
			is_push ? addr_t'(count_q) : addr_t'(count_q - 1'b1));
		wr_addr   = low_end ? ring_prev(front_q) : high_addr;
		rd_addr   = low_end ? front_q : high_addr;
		front_d   = front_q;
		count_d   = count_q;
		status_d  = ST_OK;
		if (is_push) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + 1'b1;
				if (low_end) begin
					front_d = ring_prev(front_q);
				end
			end
		end else if (is_pop) begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				count_d = count_q - 1'b1;
				if (low_end) begin
					front_d = ring_next(front_q);
				end
			end
		end
	end

	bdq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (cmd.exec && push_ok),
		.waddr(wr_addr),
		.wdata(data_q),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (cmd.exec) begin
			front_q <= front_d;
			count_q <= count_d;
			if (op_q == OP_REVERSE) begin
				rev_q <= ~rev_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= op;
			data_q <= word_to_data(value_in);
		end
		if (cmd.exec) begin
			value_out_q <= '0;
			status_q    <= status_d;
			res_count_q <= count_d;
		end else if (cmd.load_rd) begin
			value_out_q <= data_to_word(rd_data);
		end
	end

	assign value_out   = value_out_q;
	assign status      = status_q;
	assign entry_count = ecount_t'(res_count_q);
	assign is_empty    = (res_count_q == '0);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for bounded_deque_with_reverse. A clocked driver feeds
// op words from a pending list and predicts each result from its own deque
// state as the word is taken. A clocked monitor compares every result word,
// field by field, with the oldest prediction. Both sides stall at random.
// ---------------------------------------------------------------------------
module tb_top import bdq_pkg::*; ();

	localparam op_t OP_SPARE_LO = 3'd5;
	localparam op_t OP_SPARE_HI = 3'd7;
	localparam int  CALM_LO     = 250;
	localparam int  CALM_HI     = 400;
	localparam int  RAND_ITEMS  = 550;
	localparam int  LIST_MAX    = 1024;

	typedef struct packed {
		op_t   op;
		word_t value;
	} deque_cmd_t;

	typedef struct packed {
		word_t   value;
		status_t status;
		ecount_t count;
		logic    empty;
	} deque_result_t;

	logic clk;
	logic arst_n;

	bdq_in_if  req_if();
	bdq_out_if rsp_if();

	bounded_deque_with_reverse dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// pending op words and predicted results, each a list with read/write indexes
	deque_cmd_t    cmd_mem[LIST_MAX];
	deque_result_t res_mem[LIST_MAX];
	int            cmd_wr;
	int            cmd_rd;
	int            res_wr;
	int            res_rd;
	int            errors;
	int            words_sent;
	int            words_seen;

	// deque state mirror
	data_t slot_mem[DEPTH];
	int    head;
	int    fill;
	logic  flipped;

	function automatic deque_result_t deque_step(input op_t op, input word_t v);
		deque_result_t r;
		logic          low;
		r = '0;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					low = (op == OP_PUSH_FRONT) ^ flipped;
					if (low) begin
						head = (head == 0) ? DEPTH - 1 : head - 1;
						slot_mem[head] = data_t'(v);
					end else begin
						slot_mem[(head + fill) % DEPTH] = data_t'(v);
					end
					fill++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					low = (op == OP_POP_FRONT) ^ flipped;
					if (low) begin
						r.value = word_t'(slot_mem[head]);
						head = (head + 1) % DEPTH;
						fill--;
					end else begin
						fill--;
						r.value = word_t'(slot_mem[(head + fill) % DEPTH]);
					end
				end
			end
			OP_REVERSE: begin
				flipped = !flipped;
			end
			default: begin
			end
		endcase
		r.count = ecount_t'(fill);
		r.empty = (fill == 0);
		return r;
	endfunction

	function automatic bit take_break(input int n);
		return !(n >= CALM_LO && n < CALM_HI) && ($urandom_range(99, 0) < 29);
	endfunction

	task automatic add_cmd(input op_t op, input word_t v);
		cmd_mem[cmd_wr] = '{op: op, value: v};
		cmd_wr++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin : drive
		deque_cmd_t c;
		if (!arst_n) begin
			req_if.valid    <= 1'b0;
			req_if.op       <= OP_PUSH_FRONT;
			req_if.value_in <= '0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				res_mem[res_wr] = deque_step(req_if.op, req_if.value_in);
				res_wr++;
				words_sent++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (cmd_rd != cmd_wr && !take_break(words_sent)) begin
					c = cmd_mem[cmd_rd];
					cmd_rd++;
					req_if.valid    <= 1'b1;
					req_if.op       <= c.op;
					req_if.value_in <= c.value;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		deque_result_t e;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				words_seen++;
				if (res_rd == res_wr) begin
					$error("unexpected result word: value_out %h status %0d",
						rsp_if.value_out, rsp_if.status);
					errors++;
				end else begin
					e = res_mem[res_rd];
					res_rd++;
					if (rsp_if.value_out !== e.value) begin
						$error("value_out: expected %h, got %h", e.value, rsp_if.value_out);
						errors++;
					end
					if (rsp_if.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp_if.status);
						errors++;
					end
					if (rsp_if.entry_count !== e.count) begin
						$error("entry_count: expected %0d, got %0d", e.count,
							rsp_if.entry_count);
						errors++;
					end
					if (rsp_if.is_empty !== e.empty) begin
						$error("is_empty: expected %0b, got %0b", e.empty, rsp_if.is_empty);
						errors++;
					end
				end
			end
			rsp_if.ready <= !take_break(words_seen);
		end
	end

	initial begin
		int    mode;
		int    run_len;
		int    made;
		int    roll;
		int    sim_fill;
		bit    push;
		op_t   op;
		word_t v;

		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.op       = OP_PUSH_FRONT;
		req_if.value_in = '0;
		rsp_if.ready    = 1'b0;
		cmd_wr          = 0;
		cmd_rd          = 0;
		res_wr          = 0;
		res_rd          = 0;
		errors          = 0;
		words_sent      = 0;
		words_seen      = 0;
		head            = 0;
		fill            = 0;
		flipped         = 1'b0;
		foreach (slot_mem[i]) slot_mem[i] = '0;

		// empty queue corner cases and unused codes
		add_cmd(OP_POP_FRONT, 32'hFFFF_FFFF);
		add_cmd(OP_POP_BACK, 32'h1234_5678);
		add_cmd(OP_REVERSE, '0);
		add_cmd(OP_SPARE_LO, 32'hFFFF_FFFF);
		add_cmd(op_t'(OP_SPARE_LO + 1), '0);
		add_cmd(OP_SPARE_HI, 32'hA5A5_A5A5);
		// fill to the top, mixing ends, with extreme words
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0) v = '0;
			else if (i == 1) v = '1;
			else if (i[0]) v = ~(word_t'(1) << (2 * i));
			else v = word_t'(1) << (2 * i + 1);
			add_cmd(i[1] ? OP_PUSH_BACK : OP_PUSH_FRONT, v);
		end
		add_cmd(OP_PUSH_FRONT, 32'hDEAD_BEEF);
		add_cmd(OP_PUSH_BACK, 32'hFFFF_FFFF);
		add_cmd(OP_REVERSE, '0);
		add_cmd(OP_POP_FRONT, '0);
		add_cmd(OP_POP_BACK, '0);

		// random runs that swing between full, empty and mixed traffic
		sim_fill = DEPTH - 2;
		made     = 0;
		while (made < RAND_ITEMS) begin
			mode    = $urandom_range(2, 0);
			run_len = $urandom_range(40, 10);
			for (int k = 0; k < run_len && made < RAND_ITEMS; k++) begin
				roll = $urandom_range(99, 0);
				if (roll < 4) begin
					op = op_t'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
				end else if (roll < 11) begin
					op = OP_REVERSE;
				end else begin
					roll = $urandom_range(99, 0);
					if (mode == 0) push = roll < 80;
					else if (mode == 1) push = roll < 20;
					else push = roll < 50;
					if (push) begin
						op = $urandom_range(1, 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
						if (sim_fill < DEPTH) sim_fill++;
					end else begin
						op = $urandom_range(1, 0) ? OP_POP_BACK : OP_POP_FRONT;
						if (sim_fill > 0) sim_fill--;
					end
				end
				roll = $urandom_range(19, 0);
				if (roll == 0) v = '0;
				else if (roll == 1) v = '1;
				else v = $urandom;
				add_cmd(op, v);
				made++;
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (cmd_rd != cmd_wr || req_if.valid || res_rd != res_wr) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (errors == 0 && res_rd == res_wr) begin
			$display("** bounded_deque_with_reverse: PASSED **");
		end else begin
			$display("** bounded_deque_with_reverse: FAILED **");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("** bounded_deque_with_reverse: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
hdl/bdq_pkg.sv
hdl/bdq_in_if.sv
hdl/bdq_out_if.sv
hdl/bdq_ram.sv
hdl/bdq_ctrl.sv
hdl/bdq_dp.sv
hdl/bounded_deque_with_reverse.sv
tb/tb_top.sv
